// ----- design/framebuffer_rect_and_glyph_blitter_assert.svh -----
// Assertion macros shared by the blitter modules.
`ifndef FRAMEBUFFER_RECT_AND_GLYPH_BLITTER_ASSERT_SVH
`define FRAMEBUFFER_RECT_AND_GLYPH_BLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The expression must never be true.
`define FB_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

// ----- design/fbb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blitter package
// Panel geometry, command kinds, font ROM and controller/datapath types.
// ----------------------------------------------------------------------------
package fbb_pkg;

   localparam int PanelWidth  = 172;
   localparam int PanelHeight = 320;
   localparam int PixelCount  = PanelWidth * PanelHeight;
   localparam int AddrWidth   = $clog2(PixelCount);
   localparam int FontLow     = 8'h20;
   localparam int FontHigh    = 8'h5A;
   localparam int FontCount   = FontHigh - FontLow + 1;
   localparam int FontIdxWidth = $clog2(FontCount);

   // Wide enough for every intermediate coordinate of a block.
   localparam int CoordWidth = 13;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef enum logic [2:0] {
      KIND_FILL    = 3'd0,
      KIND_OUTLINE = 3'd1,
      KIND_NOTCHED = 3'd2,
      KIND_GLYPH   = 3'd3,
      KIND_READ    = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CLIP,
      ST_DRAW,
      ST_NEXT,
      ST_READ,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;        // capture a new command
      logic block_setup; // form the current block's raw rectangle
      logic clip;        // clip the raw rectangle
      logic draw;        // write one pixel and advance the scan
      logic next;        // advance to the next block of the shape
      logic read_addr;   // present the read address
      logic read_take;   // capture the read data
      logic done;        // present the result
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_read;
      logic shape_done;  // no more blocks in this shape
      logic block_empty; // clipped block writes nothing
      logic scan_last;   // the pixel being written is the block's last
   } status_type;

   function automatic logic [39:0] font_row(input logic [FontIdxWidth-1:0] idx);
      logic [39:0] r;
      case (idx)
         6'd0:  r = 40'h0000000000; 6'd1:  r = 40'h00005F0000;
         6'd2:  r = 40'h0007000700; 6'd3:  r = 40'h147F147F14;
         6'd4:  r = 40'h242A7F2A12; 6'd5:  r = 40'h2313086462;
         6'd6:  r = 40'h3649552250; 6'd7:  r = 40'h0005030000;
         6'd8:  r = 40'h001C224100; 6'd9:  r = 40'h0041221C00;
         6'd10: r = 40'h14083E0814; 6'd11: r = 40'h08083E0808;
         6'd12: r = 40'h0050300000; 6'd13: r = 40'h0808080808;
         6'd14: r = 40'h0060600000; 6'd15: r = 40'h2010080402;
         6'd16: r = 40'h3E5149453E; 6'd17: r = 40'h00427F4000;
         6'd18: r = 40'h4261514946; 6'd19: r = 40'h2141454B31;
         6'd20: r = 40'h1814127F10; 6'd21: r = 40'h2745454539;
         6'd22: r = 40'h3C4A494930; 6'd23: r = 40'h0171090503;
         6'd24: r = 40'h3649494936; 6'd25: r = 40'h064949291E;
         6'd26: r = 40'h0036360000; 6'd27: r = 40'h0056360000;
         6'd28: r = 40'h0814224100; 6'd29: r = 40'h1414141414;
         6'd30: r = 40'h0041221408; 6'd31: r = 40'h0201510906;
         6'd32: r = 40'h324979413E; 6'd33: r = 40'h7E1111117E;
         6'd34: r = 40'h7F49494936; 6'd35: r = 40'h3E41414122;
         6'd36: r = 40'h7F4141221C; 6'd37: r = 40'h7F49494941;
         6'd38: r = 40'h7F09090901; 6'd39: r = 40'h3E4149497A;
         6'd40: r = 40'h7F0808087F; 6'd41: r = 40'h00417F4100;
         6'd42: r = 40'h2040413F01; 6'd43: r = 40'h7F08142241;
         6'd44: r = 40'h7F40404040; 6'd45: r = 40'h7F020C027F;
         6'd46: r = 40'h7F0408107F; 6'd47: r = 40'h3E4141413E;
         6'd48: r = 40'h7F09090906; 6'd49: r = 40'h3E4151215E;
         6'd50: r = 40'h7F09192946; 6'd51: r = 40'h4649494931;
         6'd52: r = 40'h01017F0101; 6'd53: r = 40'h3F4040403F;
         6'd54: r = 40'h1F2040201F; 6'd55: r = 40'h3F4038403F;
         6'd56: r = 40'h6314081463; 6'd57: r = 40'h0708700807;
         6'd58: r = 40'h6151494543;
         default: r = 40'h0000000000;
      endcase
      return r;
   endfunction

endpackage

// ----- design/fbb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, with registered read data.
// ----------------------------------------------------------------------------
module fbb_ram #(
   parameter int DataWidth = 16,
   parameter int Depth     = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [DataWidth-1:0]     wr_data,
   output logic [DataWidth-1:0]     rd_data
);

   logic [DataWidth-1:0] mem_ff [Depth];
   logic [DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/fbb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blitter controller
// Sequences setup, clipping, pixel scan and read for each transaction.
// ----------------------------------------------------------------------------
`include "framebuffer_rect_and_glyph_blitter_assert.svh"

module fbb_ctrl import fbb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (status.is_read) state_in = ST_READ;
            else if (status.shape_done) state_in = ST_DONE;
            else state_in = ST_CLIP;
         end
         ST_CLIP: begin
            state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (status.block_empty || status.scan_last) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = ST_SETUP;
         end
         ST_READ: begin
            state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SETUP:     cmd.block_setup = 1'b1;
         ST_CLIP:      cmd.clip = 1'b1;
         ST_DRAW:      cmd.draw = !status.block_empty;
         ST_NEXT:      cmd.next = 1'b1;
         ST_READ:      cmd.read_addr = 1'b1;
         ST_READ_WAIT: cmd.read_take = 1'b1;
         ST_DONE:      cmd.done = 1'b1;
         default:      busy = 1'b1;
      endcase
   end

   `FB_ASSERT_NEXT(a_start_leaves_idle, clock, reset, state_ff == ST_IDLE && start,
      state_ff == ST_SETUP, "accepted transaction did not start setup")
   `FB_ASSERT_NEXT(a_done_returns_idle, clock, reset, state_ff == ST_DONE,
      state_ff == ST_IDLE, "controller did not return to idle")
   `FB_ASSERT_NEVER(a_one_cmd, clock, reset, !$onehot0(cmd),
      "controller issued more than one command")

endmodule

// ----- design/fbb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blitter datapath
// Builds, clips and scans shape blocks into the frame store; reads pixels.
// ----------------------------------------------------------------------------
`include "framebuffer_rect_and_glyph_blitter_assert.svh"

module fbb_datapath import fbb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [2:0]        req_kind,
   input  logic signed [9:0] req_pos_x,
   input  logic signed [9:0] req_pos_y,
   input  logic signed [9:0] req_extent_w,
   input  logic signed [9:0] req_extent_h,
   input  logic [7:0]        req_char_code,
   input  logic [3:0]        req_glyph_scale,
   input  logic [15:0]       req_pixel_color,
   output status_type        status,
   output logic              rsp_valid,
   output logic [15:0]       rsp_read_color
);

   logic [2:0]  kind_ff;
   coord_type   x_ff, y_ff, w_ff, h_ff;
   logic [3:0]  scale_ff;
   logic [15:0] color_ff;
   logic [39:0] font_ff;
   logic [5:0]  blk_ff, blk_in;
   logic [2:0]  dcol_ff, drow_ff;
   coord_type   bx_ff, by_ff, bw_ff, bh_ff;
   logic [9:0]  cw_ff, ch_ff;
   logic [9:0]  col_ff, row_ff;
   logic [AddrWidth-1:0] row_base_ff;
   logic        empty_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_color_ff;
   logic [7:0]  code_fold;
   logic [FontIdxWidth-1:0] font_idx;
   logic [5:0]  last_blk;
   coord_type   rx, ry, rw, rh;
   coord_type   kx, ky, kw, kh;
   logic        dot_on;
   coord_type   sc;
   logic        in_panel;
   logic        ram_we;
   logic [AddrWidth-1:0] ram_addr;
   logic [15:0] ram_rd;

   always_comb begin
      code_fold = req_char_code;
      if (req_char_code >= 8'h61 && req_char_code <= 8'h7A) begin
         code_fold = req_char_code - 8'h20;
      end
      if (code_fold < 8'(FontLow) || code_fold > 8'(FontHigh)) begin
         code_fold = 8'(FontLow);
      end
      font_idx = FontIdxWidth'(code_fold - 8'(FontLow));
   end

   always_comb begin
      case (kind_ff)
         KIND_FILL:    last_blk = 6'd0;
         KIND_OUTLINE: last_blk = 6'd3;
         KIND_NOTCHED: last_blk = 6'd6;
         KIND_GLYPH:   last_blk = 6'd34;
         default:      last_blk = 6'd0;
      endcase
   end

   // Glyph dots are walked column by column, seven rows per column.
   always_comb begin
      dot_on = font_ff[8 * (4 - int'(dcol_ff)) + int'(drow_ff)];
      sc = coord_type'(scale_ff);
   end

   // Raw rectangle of the current block.
   always_comb begin
      rx = x_ff; ry = y_ff; rw = w_ff; rh = h_ff;
      case (kind_ff)
         KIND_OUTLINE: begin
            case (blk_ff)
               6'd0: rh = 13'sd1;
               6'd1: begin ry = y_ff + h_ff - 13'sd1; rh = 13'sd1; end
               6'd2: rw = 13'sd1;
               default: begin rx = x_ff + w_ff - 13'sd1; rw = 13'sd1; end
            endcase
         end
         KIND_NOTCHED: begin
            rw = 13'sd1; rh = 13'sd1;
            case (blk_ff)
               6'd0: begin rx = x_ff + 13'sd2; rw = w_ff - 13'sd4; rh = h_ff; end
               6'd1: begin ry = y_ff + 13'sd2; rw = 13'sd2; rh = h_ff - 13'sd4; end
               6'd2: begin
                  rx = x_ff + w_ff - 13'sd2; ry = y_ff + 13'sd2;
                  rw = 13'sd2; rh = h_ff - 13'sd4;
               end
               6'd3: begin rx = x_ff + 13'sd1; ry = y_ff + 13'sd1; end
               6'd4: begin rx = x_ff + w_ff - 13'sd2; ry = y_ff + 13'sd1; end
               6'd5: begin rx = x_ff + 13'sd1; ry = y_ff + h_ff - 13'sd2; end
               default: begin rx = x_ff + w_ff - 13'sd2; ry = y_ff + h_ff - 13'sd2; end
            endcase
         end
         KIND_GLYPH: begin
            rx = x_ff + coord_type'(dcol_ff) * sc;
            ry = y_ff + coord_type'(drow_ff) * sc;
            rw = dot_on ? sc : 13'sd0;
            rh = sc;
         end
         default: begin
         end
      endcase
   end

   // Clip the registered raw block.
   always_comb begin
      kx = bx_ff; ky = by_ff; kw = bw_ff; kh = bh_ff;
      if (kx < 0) begin kw = kw + kx; kx = '0; end
      if (ky < 0) begin kh = kh + ky; ky = '0; end
      if (kx + kw > coord_type'(PanelWidth)) kw = coord_type'(PanelWidth) - kx;
      if (ky + kh > coord_type'(PanelHeight)) kh = coord_type'(PanelHeight) - ky;
   end

   always_comb begin
      blk_in = blk_ff;
      if (cmd.load) blk_in = '0;
      else if (cmd.next) blk_in = blk_ff + 6'd1;
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (cmd.load) begin
         dcol_ff <= '0;
         drow_ff <= '0;
      end else if (cmd.next) begin
         if (drow_ff == 3'd6) begin
            drow_ff <= '0;
            dcol_ff <= dcol_ff + 3'd1;
         end else begin
            drow_ff <= drow_ff + 3'd1;
         end
      end
      if (cmd.load) begin
         kind_ff  <= req_kind;
         x_ff     <= coord_type'(req_pos_x);
         y_ff     <= coord_type'(req_pos_y);
         w_ff     <= coord_type'(req_extent_w);
         h_ff     <= coord_type'(req_extent_h);
         scale_ff <= req_glyph_scale;
         color_ff <= req_pixel_color;
         font_ff  <= font_row(font_idx);
      end
      if (cmd.block_setup) begin
         bx_ff <= rx; by_ff <= ry; bw_ff <= rw; bh_ff <= rh;
      end
      if (cmd.clip) begin
         empty_ff <= (kw <= 0) || (kh <= 0);
         cw_ff    <= kw[9:0];
         ch_ff    <= kh[9:0];
         col_ff   <= '0;
         row_ff   <= '0;
         row_base_ff <= AddrWidth'(ky[8:0]) * AddrWidth'(PanelWidth)
                        + AddrWidth'(kx[8:0]);
      end else if (cmd.draw) begin
         if (col_ff == cw_ff - 10'd1) begin
            col_ff <= '0;
            row_ff <= row_ff + 10'd1;
            row_base_ff <= row_base_ff + AddrWidth'(PanelWidth);
         end else begin
            col_ff <= col_ff + 10'd1;
         end
      end
   end

   assign in_panel = x_ff >= 0 && y_ff >= 0 && x_ff < coord_type'(PanelWidth)
                     && y_ff < coord_type'(PanelHeight);

   always_comb begin
      ram_we = cmd.draw;
      if (cmd.read_addr) begin
         ram_addr = AddrWidth'(y_ff[8:0]) * AddrWidth'(PanelWidth)
                    + AddrWidth'(x_ff[8:0]);
      end else begin
         ram_addr = row_base_ff + AddrWidth'(col_ff);
      end
   end

   fbb_ram #(.DataWidth(16), .Depth(PixelCount)) u_frame (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (color_ff),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.done;
      end
      if (cmd.load) begin
         rsp_color_ff <= '0;
      end else if (cmd.read_take && in_panel) begin
         rsp_color_ff <= ram_rd;
      end
   end

   assign status.is_read     = kind_ff == KIND_READ;
   assign status.shape_done  = kind_ff > 3'(KIND_GLYPH) || blk_ff > last_blk;
   assign status.block_empty = empty_ff;
   assign status.scan_last   = col_ff == cw_ff - 10'd1 && row_ff == ch_ff - 10'd1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_color = rsp_color_ff;

   `FB_ASSERT_NEVER(a_no_write_empty, clock, reset, cmd.draw && empty_ff,
      "pixel written for an empty block")
   `FB_ASSERT_IMP(a_write_inside, clock, reset, cmd.draw,
      row_ff < ch_ff && col_ff < cw_ff, "pixel scan left its block")
   `FB_ASSERT_NEVER(a_no_color_on_draw, clock, reset,
      rsp_valid_ff && kind_ff != 3'(KIND_READ) && rsp_color_ff != 16'd0,
      "drawing transaction returned a color")

endmodule

// ----- design/framebuffer_rect_and_glyph_blitter.sv -----
`timescale 1ns / 1ps
// A read passes setup, read, read wait and done after it is accepted; a drawing
// transaction passes setup, clip, draw (one pixel at a time, none for an empty block)
// and next per block, then setup and done; rsp_valid is registered from done.
// The frame store's single port sets throughput: one pixel per cycle in the draw state.
// busy falls in the cycle of the result strobe; a new start is taken at its end.
// Synchronous reset returns the controller to idle; frame store is not cleared.
// ----------------------------------------------------------------------------
// Framebuffer rectangle and glyph blitter
// Fills, outlines, notched fills, 5x7 glyphs and pixel reads on a 16-bit store.
// ----------------------------------------------------------------------------
module framebuffer_rect_and_glyph_blitter import fbb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_kind,
   input  logic signed [9:0] req_pos_x,
   input  logic signed [9:0] req_pos_y,
   input  logic signed [9:0] req_extent_w,
   input  logic signed [9:0] req_extent_h,
   input  logic [7:0]        req_char_code,
   input  logic [3:0]        req_glyph_scale,
   input  logic [15:0]       req_pixel_color,
   output logic              rsp_valid,
   output logic [15:0]       rsp_read_color
);

   cmd_type    cmd;
   status_type status;

   fbb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   fbb_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_kind        (req_kind),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_extent_w    (req_extent_w),
      .req_extent_h    (req_extent_h),
      .req_char_code   (req_char_code),
      .req_glyph_scale (req_glyph_scale),
      .req_pixel_color (req_pixel_color),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_read_color  (rsp_read_color)
   );

endmodule

// ----- bench/tb_framebuffer_rect_and_glyph_blitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blitter testbench
// Drives fill, outline, notched, glyph, read and unknown-kind transactions with
// random gaps, keeps its own copy of the frame store and compares every read.
// ----------------------------------------------------------------------------
module tb_framebuffer_rect_and_glyph_blitter;
   import fbb_pkg::*;

   localparam int WatchdogLimit = 200000;

   class pixel_scoreboard;
      logic [15:0] frame [PixelCount];
      logic [15:0] pending [$];
      int          errors;
      logic [39:0] font [FontCount] = '{
         40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
         40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
         40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
         40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
         40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
         40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
         40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
         40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
         40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
         40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
         40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
         40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
         40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
         40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
         40'h6314081463, 40'h0708700807, 40'h6151494543};

      function void paint(int x, int y, int w, int h, logic [15:0] color);
         if (x < 0) begin
            w += x;
            x = 0;
         end
         if (y < 0) begin
            h += y;
            y = 0;
         end
         if (x + w > PanelWidth) w = PanelWidth - x;
         if (y + h > PanelHeight) h = PanelHeight - y;
         for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
               frame[(y + r) * PanelWidth + x + c] = color;
      endfunction

      function void note(logic [2:0] kind, int x, int y, int w, int h,
                         int code, int scale, logic [15:0] color);
         logic [15:0] value;
         logic [7:0]  dots;
         value = '0;
         case (kind)
            KIND_FILL: paint(x, y, w, h, color);
            KIND_OUTLINE: begin
               paint(x, y, w, 1, color);
               paint(x, y + h - 1, w, 1, color);
               paint(x, y, 1, h, color);
               paint(x + w - 1, y, 1, h, color);
            end
            KIND_NOTCHED: begin
               paint(x + 2, y, w - 4, h, color);
               paint(x, y + 2, 2, h - 4, color);
               paint(x + w - 2, y + 2, 2, h - 4, color);
               paint(x + 1, y + 1, 1, 1, color);
               paint(x + w - 2, y + 1, 1, 1, color);
               paint(x + 1, y + h - 2, 1, 1, color);
               paint(x + w - 2, y + h - 2, 1, 1, color);
            end
            KIND_GLYPH: begin
               if (code >= 8'h61 && code <= 8'h7A) code = code - 8'h20;
               if (code < FontLow || code > FontHigh) code = FontLow;
               for (int c = 0; c < 5; c++) begin
                  dots = font[code - FontLow][39 - 8 * c -: 8];
                  for (int r = 0; r < 7; r++)
                     if (dots[r]) paint(x + c * scale, y + r * scale, scale, scale, color);
               end
            end
            KIND_READ:
               if (x >= 0 && y >= 0 && x < PanelWidth && y < PanelHeight)
                  value = frame[y * PanelWidth + x];
            default: ;
         endcase
         pending.push_back(value);
      endfunction

      function void check(logic [15:0] actual);
         logic [15:0] wanted;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $realtime, actual);
            errors++;
         end else begin
            wanted = pending.pop_front();
            if (actual !== wanted) begin
               $display("%0t: read_color mismatch, expected %h, actual %h",
                        $realtime, wanted, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [2:0]        req_kind = '0;
   logic signed [9:0] req_pos_x = '0;
   logic signed [9:0] req_pos_y = '0;
   logic signed [9:0] req_extent_w = '0;
   logic signed [9:0] req_extent_h = '0;
   logic [7:0]        req_char_code = '0;
   logic [3:0]        req_glyph_scale = '0;
   logic [15:0]       req_pixel_color = '0;
   logic              rsp_valid;
   logic [15:0]       rsp_read_color;

   pixel_scoreboard board = new();
   int              quiet_cycles;

   always #5 clock = ~clock;

   framebuffer_rect_and_glyph_blitter u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_extent_w(req_extent_w), .req_extent_h(req_extent_h),
      .req_char_code(req_char_code), .req_glyph_scale(req_glyph_scale),
      .req_pixel_color(req_pixel_color), .rsp_valid(rsp_valid),
      .rsp_read_color(rsp_read_color)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (!reset && rsp_valid) board.check(rsp_read_color);
      if (quiet_cycles >= WatchdogLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send(logic [2:0] kind, int x, int y, int w, int h,
                       int code, int scale, int color);
      req_kind <= kind;
      req_pos_x <= 10'(x);
      req_pos_y <= 10'(y);
      req_extent_w <= 10'(w);
      req_extent_h <= 10'(h);
      req_char_code <= 8'(code);
      req_glyph_scale <= 4'(scale);
      req_pixel_color <= 16'(color);
      start <= 1'b1;
      do @(posedge clock); while (busy);
      board.note(kind, x, y, w, h, code, scale, 16'(color));
      @(negedge clock);
   endtask

   task automatic pause(bit allowed);
      if (allowed && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   function automatic int pick_extent();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return $urandom_range(0, 1023) - 512;
      if (roll < 3) return -$urandom_range(0, 8);
      return $urandom_range(0, 24);
   endfunction

   function automatic int pick_pos(int span);
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1023) - 512;
      return $urandom_range(0, span + 16) - 8;
   endfunction

   initial begin
      int k, w, h;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(KIND_FILL, 0, 0, 511, 511, 0, 0, 16'h1234);
      send(KIND_READ, 0, 0, 0, 0, 0, 0, 0);
      send(KIND_READ, 171, 319, 0, 0, 0, 0, 0);
      send(KIND_READ, 172, 5, 0, 0, 0, 0, 0);
      send(KIND_READ, -1, 5, 0, 0, 0, 0, 0);
      send(KIND_READ, 5, 320, 0, 0, 0, 0, 0);
      send(KIND_READ, 5, -512, 0, 0, 0, 0, 0);
      send(KIND_FILL, -512, -512, 511, 511, 0, 0, 16'hFFFF);
      send(KIND_FILL, -3, -4, 8, 9, 0, 0, 16'hFFFF);
      send(KIND_READ, 4, 4, 0, 0, 0, 0, 0);
      send(KIND_FILL, 10, 10, 0, 5, 0, 0, 16'h0000);
      send(KIND_FILL, 10, 10, -512, 5, 0, 0, 16'h0000);
      send(KIND_OUTLINE, 20, 20, 6, 5, 0, 0, 16'hA5A5);
      send(KIND_READ, 25, 24, 0, 0, 0, 0, 0);
      send(KIND_NOTCHED, 30, 30, 8, 8, 0, 0, 16'h5A5A);
      send(KIND_READ, 31, 31, 0, 0, 0, 0, 0);
      send(KIND_READ, 30, 30, 0, 0, 0, 0, 0);
      send(KIND_GLYPH, 40, 40, 0, 0, 8'h30, 2, 16'h0F0F);
      send(KIND_GLYPH, 60, 40, 0, 0, 8'h61, 1, 16'hF0F0);
      send(KIND_GLYPH, 70, 40, 0, 0, 8'hFF, 3, 16'h1111);
      send(KIND_GLYPH, 160, 300, 0, 0, 8'h5A, 15, 16'h2222);
      send(KIND_GLYPH, 80, 40, 0, 0, 8'h41, 0, 16'h3333);
      send(3'd5, 0, 0, 0, 0, 0, 0, 0);
      send(3'd7, 511, 511, 511, 511, 255, 15, 16'hFFFF);
      send(KIND_READ, 41, 41, 0, 0, 0, 0, 0);

      for (int i = 0; i < 750; i++) begin
         pause(i < 650);
         k = $urandom_range(0, 99);
         w = pick_extent();
         h = pick_extent();
         if (w > 64 && h > 64) h = $urandom_range(0, 24);
         if (k < 30)
            send(KIND_READ, pick_pos(PanelWidth), pick_pos(PanelHeight), $urandom, $urandom,
                 $urandom, $urandom, $urandom);
         else if (k < 97)
            send(k < 45 ? KIND_FILL : k < 60 ? KIND_OUTLINE : k < 75 ? KIND_NOTCHED
                 : KIND_GLYPH, pick_pos(PanelWidth), pick_pos(PanelHeight), w, h,
                 $urandom_range(0, 255),
                 $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 4),
                 $urandom_range(0, 65535));
         else
            send(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
      end
      start <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
